/* rtl/sepia_tone_filter_packed_bgr_assert.svh */
// ----------------------------------------------------------------------------
// Sepia tone filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEPIA_TONE_FILTER_PACKED_BGR_ASSERT_SVH
`define SEPIA_TONE_FILTER_PACKED_BGR_ASSERT_SVH

// Same-cycle implication.
`define STF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sepia filter: same-cycle check failed");

// Next-cycle implication.
`define STF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sepia filter: next-cycle check failed");

`endif

/* rtl/stf_pkg.sv */
// ----------------------------------------------------------------------------
// Sepia tone filter package
// Matrix coefficients, divider constants, codes and shared types.
// ----------------------------------------------------------------------------
package stf_pkg;

    localparam int PIX_PER_GROUP = 8;
    localparam int BEAT_W        = 64;
    localparam int GROUP_W       = 3 * BEAT_W;
    localparam int PIX_W         = 24;
    localparam int CFG_W         = 12;
    localparam int COUNT_W       = 24;

    // Sum of three channel products: at most 1351 * 255 fits 19 bits
    localparam int SUM_W    = 19;
    localparam int DIV_IN_W = 18;
    localparam int RECIP_W  = 19;
    localparam int PROD_W   = DIV_IN_W + RECIP_W;

    localparam logic [SUM_W-1:0] K_R_R = 19'd393;
    localparam logic [SUM_W-1:0] K_R_G = 19'd769;
    localparam logic [SUM_W-1:0] K_R_B = 19'd189;
    localparam logic [SUM_W-1:0] K_G_R = 19'd349;
    localparam logic [SUM_W-1:0] K_G_G = 19'd686;
    localparam logic [SUM_W-1:0] K_G_B = 19'd168;
    localparam logic [SUM_W-1:0] K_B_R = 19'd272;
    localparam logic [SUM_W-1:0] K_B_G = 19'd534;
    localparam logic [SUM_W-1:0] K_B_B = 19'd131;

    // 256 * 1000: at or above this the quotient saturates
    localparam logic [SUM_W-1:0] SAT_LIMIT = 19'd256000;
    // ceil(2^28 / 1000); exact floor division for sums below SAT_LIMIT
    localparam logic [RECIP_W-1:0] RECIP_M = 19'd268436;
    localparam int RECIP_SHIFT = 28;
    localparam logic [7:0] CHAN_MAX = 8'hff;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    localparam logic [1:0] BEAT_FIRST  = 2'd0;
    localparam logic [1:0] BEAT_SECOND = 2'd1;
    localparam logic [1:0] BEAT_LAST   = 2'd2;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_STEP = 24'd8;
    localparam logic [CFG_W-1:0]   CFG_RESET  = 12'd1;

    typedef struct packed {
        logic load;
        logic last;
    } merge_ctrl_t;

endpackage

/* rtl/stf_lane.sv */
// ----------------------------------------------------------------------------
// Sepia tone filter lane
// One pixel: weighted channel sums, then saturating divide by 1000.
// ----------------------------------------------------------------------------
module stf_lane
(
    input  logic                       clk,
    input  logic                       sum_en,
    input  logic                       res_en,
    input  logic [stf_pkg::PIX_W-1:0]  pix_in,   // B, G, R from bit 0 up
    output logic [stf_pkg::PIX_W-1:0]  pix_out   // B, G, R from bit 0 up
);

    logic [stf_pkg::SUM_W-1:0] b_ext;
    logic [stf_pkg::SUM_W-1:0] g_ext;
    logic [stf_pkg::SUM_W-1:0] r_ext;
    logic [stf_pkg::SUM_W-1:0] sum_r_reg;
    logic [stf_pkg::SUM_W-1:0] sum_g_reg;
    logic [stf_pkg::SUM_W-1:0] sum_b_reg;
    logic [stf_pkg::SUM_W-1:0] sum_r_next;
    logic [stf_pkg::SUM_W-1:0] sum_g_next;
    logic [stf_pkg::SUM_W-1:0] sum_b_next;
    logic [stf_pkg::PIX_W-1:0] res_reg;
    logic [stf_pkg::PIX_W-1:0] res_next;

    // Divide by 1000 through a reciprocal multiply, clamp at 255
    function automatic logic [7:0] sat_div(input logic [stf_pkg::SUM_W-1:0] sum);
        logic [stf_pkg::PROD_W-1:0] prod;
        logic [7:0]                 q;
        prod = {{stf_pkg::RECIP_W{1'b0}}, sum[stf_pkg::DIV_IN_W-1:0]}
             * {{stf_pkg::DIV_IN_W{1'b0}}, stf_pkg::RECIP_M};
        q = prod[stf_pkg::RECIP_SHIFT +: 8];
        return (sum >= stf_pkg::SAT_LIMIT) ? stf_pkg::CHAN_MAX : q;
    endfunction

    assign b_ext = {{(stf_pkg::SUM_W-8){1'b0}}, pix_in[7:0]};
    assign g_ext = {{(stf_pkg::SUM_W-8){1'b0}}, pix_in[15:8]};
    assign r_ext = {{(stf_pkg::SUM_W-8){1'b0}}, pix_in[23:16]};

    always_comb
    begin
        sum_r_next = stf_pkg::K_R_R * r_ext + stf_pkg::K_R_G * g_ext
                   + stf_pkg::K_R_B * b_ext;
        sum_g_next = stf_pkg::K_G_R * r_ext + stf_pkg::K_G_G * g_ext
                   + stf_pkg::K_G_B * b_ext;
        sum_b_next = stf_pkg::K_B_R * r_ext + stf_pkg::K_B_G * g_ext
                   + stf_pkg::K_B_B * b_ext;
        res_next   = {sat_div(sum_r_reg), sat_div(sum_g_reg), sat_div(sum_b_reg)};
    end

    always_ff @(posedge clk)
    begin
        if (sum_en)
        begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
        end
        if (res_en)
        begin
            res_reg <= res_next;
        end
    end

    assign pix_out = res_reg;

endmodule

/* rtl/stf_merge.sv */
// ----------------------------------------------------------------------------
// Sepia tone filter output merge
// Gather the eight lane results and send them out as three beats.
// ----------------------------------------------------------------------------
`include "sepia_tone_filter_packed_bgr_assert.svh"

module stf_merge
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  stf_pkg::merge_ctrl_t          ctrl,
    input  logic [stf_pkg::GROUP_W-1:0]   group_data,
    output logic                          ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stf_pkg::BEAT_W-1:0]    m_tdata,   // result_data[63:0]
    output logic                          m_tlast    // frame_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       last_reg;
    logic       last_next;
    logic       beat_done;
    logic       group_done;

    assign beat_done  = valid_reg && m_tready;
    assign group_done = beat_done && (idx_reg == stf_pkg::BEAT_LAST);
    assign ready      = !valid_reg || group_done;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        priority if (ctrl.load)
        begin
            valid_next = 1'b1;
            idx_next   = stf_pkg::BEAT_FIRST;
            last_next  = ctrl.last;
        end
        else if (group_done)
        begin
            valid_next = 1'b0;
            idx_next   = stf_pkg::BEAT_FIRST;
        end
        else if (beat_done)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= stf_pkg::BEAT_FIRST;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        unique case (idx_reg)
            stf_pkg::BEAT_FIRST:  m_tdata = group_data[0 +: stf_pkg::BEAT_W];
            stf_pkg::BEAT_SECOND: m_tdata = group_data[stf_pkg::BEAT_W +: stf_pkg::BEAT_W];
            stf_pkg::BEAT_LAST:   m_tdata = group_data[2*stf_pkg::BEAT_W +: stf_pkg::BEAT_W];
            default:              m_tdata = '0;
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = valid_reg && last_reg && (idx_reg == stf_pkg::BEAT_LAST);

    `STF_ASSERT_IMP(a_last_on_final_beat, m_tvalid && m_tlast, idx_reg == stf_pkg::BEAT_LAST)
    `STF_ASSERT_NXT(a_stall_holds_beat, m_tvalid && !m_tready, m_tvalid && $stable(idx_reg))

endmodule

/* rtl/sepia_tone_filter_packed_bgr.sv */
// ----------------------------------------------------------------------------
// Sepia tone filter, packed BGR stream
// Eight parallel pixel lanes apply the sepia matrix to each 3-beat group.
// ----------------------------------------------------------------------------
// Path: the group's third input item is registered in s1, the lane sums in s2,
//   the lane divide results in the merge; beats then leave one a cycle with m_tready.
// Throughput: one input item per cycle sustained while m_tready stays high; the
//   output merge drains a group's three beats while the next group's three items come in.
// Reset (rst_n low, asynchronous): beat phase, pixel count and all valid
//   flags clear; frame_rows and frame_columns return to 1.
`include "sepia_tone_filter_packed_bgr_assert.svh"

module sepia_tone_filter_packed_bgr
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [stf_pkg::CFG_W-1:0]    cfg_wdata,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [stf_pkg::BEAT_W-1:0]   s_tdata,   // beat_data[63:0]
    // output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [stf_pkg::BEAT_W-1:0]   m_tdata,   // result_data[63:0]
    output logic                         m_tlast    // frame_last
);

    // configuration
    logic [stf_pkg::CFG_W-1:0]   rows_reg;
    logic [stf_pkg::CFG_W-1:0]   cols_reg;

    // group assembly
    logic [1:0]                  phase_reg;
    logic [1:0]                  phase_next;
    logic [stf_pkg::BEAT_W-1:0]  held0_reg;
    logic [stf_pkg::BEAT_W-1:0]  held1_reg;
    logic [stf_pkg::COUNT_W-1:0] count_reg;
    logic [stf_pkg::COUNT_W-1:0] count_next;

    // pipeline control
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic                        s1_last_reg;
    logic [stf_pkg::GROUP_W-1:0] s1_data_reg;
    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    logic                        s2_last_reg;

    logic                        is_third;
    logic                        accept;
    logic                        group_in;
    logic                        frame_end;
    logic [stf_pkg::COUNT_W-1:0] frame_total;
    logic [stf_pkg::COUNT_W:0]   count_plus;
    logic                        merge_ready;
    logic                        s1_move;
    logic                        s1_ready;
    logic                        s2_move;
    logic                        s2_ready;
    logic [stf_pkg::GROUP_W-1:0] lane_out;
    stf_pkg::merge_ctrl_t        merge_ctrl;

    // Configuration registers: taken on any cycle with the write enable high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= stf_pkg::CFG_RESET;
            cols_reg <= stf_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stf_pkg::REG_ROWS: rows_reg <= cfg_wdata;
                stf_pkg::REG_COLS: cols_reg <= cfg_wdata;
                default:           rows_reg <= rows_reg;
            endcase
        end
    end

    // Frame end test: count plus this group reaches rows * columns
    assign frame_total = {{stf_pkg::CFG_W{1'b0}}, rows_reg}
                       * {{stf_pkg::CFG_W{1'b0}}, cols_reg};
    assign count_plus  = {1'b0, count_reg} + {1'b0, stf_pkg::COUNT_STEP};
    assign frame_end   = count_plus >= {1'b0, frame_total};

    // Backpressure chain: each stage advances when the one after it has room.
    // An idle phase slot never stalls; only the group-closing item waits.
    assign s2_move  = s2_valid_reg && merge_ready;
    assign s2_ready = !s2_valid_reg || merge_ready;
    assign s1_move  = s1_valid_reg && s2_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    // An unused phase code behaves as the third beat
    assign is_third = phase_reg >= stf_pkg::PH_THIRD;
    assign s_tready = !is_third || s1_ready;
    assign accept   = s_tvalid && s_tready;
    assign group_in = accept && is_third;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (accept)
        begin
            phase_next = is_third ? stf_pkg::PH_FIRST : phase_reg + 2'd1;
        end
        if (group_in)
        begin
            count_next = frame_end ? '0 : count_plus[stf_pkg::COUNT_W-1:0];
        end
        s1_valid_next = group_in ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= stf_pkg::PH_FIRST;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload: hold the first two items, then capture the whole group
    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == stf_pkg::PH_FIRST))
        begin
            held0_reg <= s_tdata;
        end
        if (accept && (phase_reg == stf_pkg::PH_SECOND))
        begin
            held1_reg <= s_tdata;
        end
        if (group_in)
        begin
            s1_data_reg <= {s_tdata, held1_reg, held0_reg};
            s1_last_reg <= frame_end;
        end
        if (s1_move)
        begin
            s2_last_reg <= s1_last_reg;
        end
    end

    // Eight lanes, one per pixel; byte layout B, G, R repeats across the group
    for (genvar p = 0; p < stf_pkg::PIX_PER_GROUP; p++)
    begin : g_lane
        stf_lane u_lane
        (
            .clk     (clk),
            .sum_en  (s1_move),
            .res_en  (s2_move),
            .pix_in  (s1_data_reg[p*stf_pkg::PIX_W +: stf_pkg::PIX_W]),
            .pix_out (lane_out[p*stf_pkg::PIX_W +: stf_pkg::PIX_W])
        );
    end

    assign merge_ctrl.load = s2_move;
    assign merge_ctrl.last = s2_last_reg;

    stf_merge u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (merge_ctrl),
        .group_data (lane_out),
        .ready      (merge_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    `STF_ASSERT_NXT(a_group_fills_s1, group_in, s1_valid_reg)
    `STF_ASSERT_IMP(a_stall_needs_full_pipe, !s_tready, is_third && s1_valid_reg && s2_valid_reg)
    `STF_ASSERT_NXT(a_count_clears_on_end, group_in && frame_end, count_reg == '0)

endmodule

/* test/sepia_tone_filter_packed_bgr_checker.sv */
// ----------------------------------------------------------------------------
// Sepia tone filter checker
// Watches the register port and both streams, predicts the toned beats of
// every accepted group and compares each output item with the oldest one.
// ----------------------------------------------------------------------------
module sepia_tone_filter_packed_bgr_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [stf_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [stf_pkg::BEAT_W-1:0]   s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [stf_pkg::BEAT_W-1:0]   m_tdata,
    input  logic                         m_tlast,
    output int                           mismatches,
    output int                           pending
);

    typedef struct packed {
        logic [stf_pkg::BEAT_W-1:0] data;
        logic                       last;
    } toned_beat_t;

    toned_beat_t                   toned_q[$];
    toned_beat_t                   oldest;
    logic [stf_pkg::CFG_W-1:0]     rows_cfg;
    logic [stf_pkg::CFG_W-1:0]     cols_cfg;
    logic [stf_pkg::BEAT_W-1:0]    held_beat [2];
    logic [1:0]                    group_phase;
    logic [stf_pkg::COUNT_W-1:0]   pixel_count;
    logic [stf_pkg::GROUP_W-1:0]   toned_group;
    int unsigned                   frame_total;
    logic                          frame_end;
    int unsigned                   result_no;

    // One output channel: weighted sum, truncating divide, clamp at 255.
    function automatic logic [7:0] tone_channel(input int unsigned kr, input int unsigned kg,
                                                input int unsigned kb, input logic [23:0] pix);
        int unsigned quotient;
        quotient = (kr * pix[23:16] + kg * pix[15:8] + kb * pix[7:0]) / 1000;
        return (quotient > 255) ? 8'hff : quotient[7:0];
    endfunction

    // Eight pixels, B in the low byte of each, R in the high byte.
    function automatic logic [stf_pkg::GROUP_W-1:0] tone_group(
        input logic [stf_pkg::GROUP_W-1:0] grp);
        logic [stf_pkg::GROUP_W-1:0] toned;
        logic [23:0]                 pix;
        for (int p = 0; p < stf_pkg::PIX_PER_GROUP; p++)
        begin
            pix = grp[p*24 +: 24];
            toned[p*24 +: 24] = {tone_channel(393, 769, 189, pix),
                                 tone_channel(349, 686, 168, pix),
                                 tone_channel(272, 534, 131, pix)};
        end
        return toned;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR output item %0d: %s got %h want %h", result_no, what, got, want);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg    = stf_pkg::CFG_RESET;
            cols_cfg    = stf_pkg::CFG_RESET;
            group_phase = stf_pkg::PH_FIRST;
            pixel_count = '0;
            toned_q.delete();
            mismatches  = 0;
            result_no   = 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == stf_pkg::REG_ROWS)
                    rows_cfg = cfg_wdata;
                else
                    cols_cfg = cfg_wdata;
            end

            if (m_tvalid && m_tready)
            begin
                if (toned_q.size() == 0)
                    report_mismatch("unexpected item", m_tdata, '0);
                else
                begin
                    oldest = toned_q.pop_front();
                    if (m_tdata !== oldest.data)
                        report_mismatch("result_data", m_tdata, oldest.data);
                    if (m_tlast !== oldest.last)
                        report_mismatch("frame_last", {63'b0, m_tlast}, {63'b0, oldest.last});
                end
                result_no++;
            end

            if (s_tvalid && s_tready)
            begin
                case (group_phase)
                    stf_pkg::PH_FIRST:
                    begin
                        held_beat[0] = s_tdata;
                        group_phase  = stf_pkg::PH_SECOND;
                    end
                    stf_pkg::PH_SECOND:
                    begin
                        held_beat[1] = s_tdata;
                        group_phase  = stf_pkg::PH_THIRD;
                    end
                    default:
                    begin
                        toned_group = tone_group({s_tdata, held_beat[1], held_beat[0]});
                        frame_total = rows_cfg * cols_cfg;
                        frame_end   = (pixel_count + stf_pkg::PIX_PER_GROUP) >= frame_total;
                        toned_q.push_back('{toned_group[63:0], 1'b0});
                        toned_q.push_back('{toned_group[127:64], 1'b0});
                        toned_q.push_back('{toned_group[191:128], frame_end});
                        pixel_count = frame_end ? '0 : pixel_count + stf_pkg::COUNT_STEP;
                        group_phase = stf_pkg::PH_FIRST;
                    end
                endcase
            end

            pending <= toned_q.size();
        end
    end

endmodule

/* test/sepia_tone_filter_packed_bgr_tb.sv */
// ----------------------------------------------------------------------------
// Sepia tone filter testbench
// Streams directed and random pixel groups through the filter under several
// frame sizes, with random idling on both streams and one long output stall;
// the checker beside the block predicts and compares every output item.
// ----------------------------------------------------------------------------
module sepia_tone_filter_packed_bgr_tb;

    // Cycles with no handshake on either stream and no register write before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // Receiver hold-off long enough to fill the block and stall its input
    localparam int LONG_HOLD   = 60;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic                         cfg_index;
    logic [stf_pkg::CFG_W-1:0]    cfg_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [stf_pkg::BEAT_W-1:0]   s_tdata;     // beat_data[63:0]
    logic                         m_tvalid;
    logic                         m_tready;
    logic [stf_pkg::BEAT_W-1:0]   m_tdata;     // result_data[63:0]
    logic                         m_tlast;     // frame_last

    int  mismatches;
    int  pending;
    int  sent_items;
    int  quiet_cycles = 0;
    bit  tail_quiet   = 1'b0;
    bit  hold_request = 1'b0;

    sepia_tone_filter_packed_bgr uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    sepia_tone_filter_packed_bgr_checker tone_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Random beat: mostly uniform bytes, sometimes pinned to the extremes or
    // pushed high so that the clamp at 255 is hit often.
    function automatic logic [stf_pkg::BEAT_W-1:0] random_beat();
        logic [stf_pkg::BEAT_W-1:0] beat;
        int                         mode;
        mode = $urandom_range(0, 3);
        beat = {$urandom, $urandom};
        for (int n = 0; n < 8; n++)
        begin
            if (mode == 2)
            begin
                case ($urandom_range(0, 2))
                    0: beat[n*8 +: 8] = 8'h00;
                    1: beat[n*8 +: 8] = 8'hff;
                    default: ;
                endcase
            end
            else if (mode == 3)
                beat[n*8 +: 8] = 8'(192 + $urandom_range(0, 63));
        end
        return beat;
    endfunction

    // Offer one item, sometimes after a random gap; return at the edge where
    // it is accepted, so the caller drives the next value in that same step.
    task automatic send_beat(input logic [stf_pkg::BEAT_W-1:0] beat);
        int gap;
        if (!tail_quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_tready);
        sent_items++;
    endtask

    task automatic send_group(input logic [stf_pkg::GROUP_W-1:0] grp);
        for (int b = 0; b < 3; b++)
            send_beat(grp[b*64 +: 64]);
    endtask

    // Drop valid and hold until every predicted item has come out, then let
    // the pipeline settle before touching the registers.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write both size registers on back-to-back edges, enable held high.
    task automatic set_frame(input int rows, input int cols);
        cfg_we    <= 1'b1;
        cfg_index <= stf_pkg::REG_ROWS;
        cfg_wdata <= rows[stf_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= stf_pkg::REG_COLS;
        cfg_wdata <= cols[stf_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Item counts need not be multiples of three, so size changes can also land in
    // the middle of a group.
    task automatic run_phase(input int rows, input int cols, input int items);
        wait_idle();
        set_frame(rows, cols);
        repeat (items) send_beat(random_beat());
    endtask

    // Receiver: random stall bursts, one long hold-off on request, and no
    // stalls at all once the tail of the run starts.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            else if (!tail_quiet && $urandom_range(0, 5) == 0)
                gap = $urandom_range(1, 11);
            else
                gap = 0;

            if (gap == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Watchdog: count cycles with no handshake and no register write.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int  rows_pick;
        int  cols_pick;
        bit  first_random;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = stf_pkg::REG_ROWS;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        sent_items = 0;
        first_random = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed groups under the reset size of one pixel: every group
        // closes a frame. Cover black, white (clamped), each pure primary at
        // full scale and alternating bit patterns.
        send_group('0);
        send_group({24{8'hff}});
        send_group({8{24'h0000ff}});
        send_group({8{24'h00ff00}});
        send_group({8{24'hff0000}});
        send_group({24{8'haa}});
        send_group({24{8'h55}});

        // Largest frame: the pixel count climbs with no frame end in sight.
        run_phase(4095, 4095, 30);
        // Shrink below the count already reached: the next group ends it.
        run_phase(1, 8, 9);
        // Zero size through either register: every group ends a frame.
        run_phase(0, 4095, 12);
        run_phase(4095, 0, 12);

        // Random sizes, mostly small so frames end often; the first phase
        // also holds the output off long enough to back up the input.
        while (sent_items < 300)
        begin
            rows_pick = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4095)
                                                    : $urandom_range(1, 6);
            cols_pick = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4095)
                                                    : $urandom_range(1, 12);
            if (first_random)
            begin
                wait_idle();
                set_frame(rows_pick, cols_pick);
                hold_request = 1'b1;
                repeat (40) send_beat(random_beat());
                first_random = 1'b0;
            end
            else
                run_phase(rows_pick, cols_pick, $urandom_range(20, 50));
        end

        // Tail: full rate on both sides.
        tail_quiet = 1'b1;
        run_phase(3, 5, 30);

        wait_idle();
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sepia_tone_filter_packed_bgr.f */
+incdir+rtl
rtl/stf_pkg.sv
rtl/stf_lane.sv
rtl/stf_merge.sv
rtl/sepia_tone_filter_packed_bgr.sv
test/sepia_tone_filter_packed_bgr_checker.sv
test/sepia_tone_filter_packed_bgr_tb.sv
